// ===== src/gpioed_pkg.sv =====
// ----------------------------------------------------------------------------
// gpioed_pkg
// Shared types, register map and masks for the GPIO edge-detect block.
// ----------------------------------------------------------------------------
package gpioed_pkg;

  localparam int NUM_PINS   = 54;
  localparam int FSEL_WORDS = 6;
  localparam int PULL_WORDS = 4;

  localparam logic [63:0] PIN_MASK = (NUM_PINS >= 64) ? {64{1'b1}} :
                                     ((64'd1 << NUM_PINS) - 64'd1);

  localparam logic [2:0] FN_OUTPUT = 3'b001;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [5:0] ADDR_FSEL0 = 6'd0;
  localparam logic [5:0] ADDR_FSEL1 = 6'd1;
  localparam logic [5:0] ADDR_FSEL2 = 6'd2;
  localparam logic [5:0] ADDR_FSEL3 = 6'd3;
  localparam logic [5:0] ADDR_FSEL4 = 6'd4;
  localparam logic [5:0] ADDR_FSEL5 = 6'd5;
  localparam logic [5:0] ADDR_SET0  = 6'd7;
  localparam logic [5:0] ADDR_SET1  = 6'd8;
  localparam logic [5:0] ADDR_CLR0  = 6'd10;
  localparam logic [5:0] ADDR_CLR1  = 6'd11;
  localparam logic [5:0] ADDR_LEV0  = 6'd13;
  localparam logic [5:0] ADDR_LEV1  = 6'd14;
  localparam logic [5:0] ADDR_EDS0  = 6'd16;
  localparam logic [5:0] ADDR_EDS1  = 6'd17;
  localparam logic [5:0] ADDR_REN0  = 6'd19;
  localparam logic [5:0] ADDR_REN1  = 6'd20;
  localparam logic [5:0] ADDR_FEN0  = 6'd22;
  localparam logic [5:0] ADDR_FEN1  = 6'd23;
  localparam logic [5:0] ADDR_PULL0 = 6'd57;
  localparam logic [5:0] ADDR_PULL1 = 6'd58;
  localparam logic [5:0] ADDR_PULL2 = 6'd59;
  localparam logic [5:0] ADDR_PULL3 = 6'd60;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  reg_addr;
    logic [31:0] wdata;
    logic [63:0] pad_levels;
  } gpioed_in_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic [63:0] pin_drive;
    logic [63:0] pin_drive_enable;
    logic        irq;
  } gpioed_out_t;

  function automatic logic [31:0] field_mask(int word, int per, int bits);
    logic [31:0] m;
    m = '0;
    for (int k = 0; k < per; k++) begin
      if (word * per + k < NUM_PINS) begin
        for (int b = 0; b < bits; b++) begin
          m[k * bits + b] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  function automatic logic [FSEL_WORDS-1:0][31:0] fsel_masks();
    logic [FSEL_WORDS-1:0][31:0] m;
    for (int w = 0; w < FSEL_WORDS; w++) begin
      m[w] = field_mask(w, 10, 3);
    end
    return m;
  endfunction

  function automatic logic [PULL_WORDS-1:0][31:0] pull_masks();
    logic [PULL_WORDS-1:0][31:0] m;
    for (int w = 0; w < PULL_WORDS; w++) begin
      m[w] = field_mask(w, 16, 2);
    end
    return m;
  endfunction

  localparam logic [FSEL_WORDS-1:0][31:0] FSEL_MASK = fsel_masks();
  localparam logic [PULL_WORDS-1:0][31:0] PULL_MASK = pull_masks();

  function automatic logic [63:0] half_to_pins(logic [31:0] d, logic hi);
    return (hi ? {d, 32'd0} : {32'd0, d}) & PIN_MASK;
  endfunction

endpackage

// ===== src/gpio_controller_edge_detect.sv =====
// ----------------------------------------------------------------------------
// gpio_controller_edge_detect
// GPIO register block: function select, output latch, level sampling,
// rising/falling edge events with irq, and pull select.
// ----------------------------------------------------------------------------
// Every input transaction (register write, register read or pad sample tick)
// produces exactly one result transaction, registered in the cycle after accept.
// A transaction can be accepted every cycle; the single output register holds
// a result while out_ready is low, and in_ready drops only when that register
// is full and not being drained. Results show the read data (zero for writes
// and ticks) and the latch, drive enables and irq after the transaction.
module gpio_controller_edge_detect
  import gpioed_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  gpioed_in_t  in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output gpioed_out_t out_data
);

  logic [FSEL_WORDS-1:0][31:0] fsel_r, fsel_nxt;
  logic [PULL_WORDS-1:0][31:0] pull_r, pull_nxt;
  logic [63:0] latch_r, latch_nxt;
  logic [63:0] levels_r, levels_nxt;
  logic [63:0] events_r, events_nxt;
  logic [63:0] rise_en_r, rise_en_nxt;
  logic [63:0] fall_en_r, fall_en_nxt;
  logic        out_valid_r, out_valid_nxt;
  gpioed_out_t out_r, out_nxt;

  logic        in_fire;
  logic [5:0]  addr;
  logic [31:0] wd;
  logic [63:0] pads;
  logic [2:0]  fidx;
  logic [1:0]  pidx;
  logic [5:0]  poff;
  logic [31:0] rdata;
  logic [63:0] drive_en;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign addr     = in_data.reg_addr;
  assign wd       = in_data.wdata;
  assign pads     = in_data.pad_levels & PIN_MASK;
  assign fidx     = addr[2:0];
  assign poff     = addr - ADDR_PULL0;
  assign pidx     = poff[1:0];

  always_comb begin
    fsel_nxt    = fsel_r;
    pull_nxt    = pull_r;
    latch_nxt   = latch_r;
    levels_nxt  = levels_r;
    events_nxt  = events_r;
    rise_en_nxt = rise_en_r;
    fall_en_nxt = fall_en_r;
    rdata       = '0;
    if (in_fire) begin
      unique case (in_data.req_type)
        REQ_WRITE: begin
          unique case (addr)
            ADDR_FSEL0, ADDR_FSEL1, ADDR_FSEL2,
            ADDR_FSEL3, ADDR_FSEL4, ADDR_FSEL5: begin
              fsel_nxt[fidx] = wd & FSEL_MASK[fidx];
            end
            ADDR_SET0, ADDR_SET1: begin
              latch_nxt = latch_r | half_to_pins(wd, addr == ADDR_SET1);
            end
            ADDR_CLR0, ADDR_CLR1: begin
              latch_nxt = latch_r & ~half_to_pins(wd, addr == ADDR_CLR1);
            end
            ADDR_EDS0, ADDR_EDS1: begin
              events_nxt = events_r & ~half_to_pins(wd, addr == ADDR_EDS1);
            end
            ADDR_REN0, ADDR_REN1: begin
              rise_en_nxt = (rise_en_r & ~half_to_pins('1, addr == ADDR_REN1))
                          | half_to_pins(wd, addr == ADDR_REN1);
            end
            ADDR_FEN0, ADDR_FEN1: begin
              fall_en_nxt = (fall_en_r & ~half_to_pins('1, addr == ADDR_FEN1))
                          | half_to_pins(wd, addr == ADDR_FEN1);
            end
            ADDR_PULL0, ADDR_PULL1, ADDR_PULL2, ADDR_PULL3: begin
              pull_nxt[pidx] = wd & PULL_MASK[pidx];
            end
            default: ;
          endcase
        end
        REQ_READ: begin
          unique case (addr)
            ADDR_FSEL0, ADDR_FSEL1, ADDR_FSEL2,
            ADDR_FSEL3, ADDR_FSEL4, ADDR_FSEL5: rdata = fsel_r[fidx];
            ADDR_LEV0: rdata = levels_r[31:0];
            ADDR_LEV1: rdata = levels_r[63:32];
            ADDR_EDS0: rdata = events_r[31:0];
            ADDR_EDS1: rdata = events_r[63:32];
            ADDR_REN0: rdata = rise_en_r[31:0];
            ADDR_REN1: rdata = rise_en_r[63:32];
            ADDR_FEN0: rdata = fall_en_r[31:0];
            ADDR_FEN1: rdata = fall_en_r[63:32];
            ADDR_PULL0, ADDR_PULL1, ADDR_PULL2, ADDR_PULL3: rdata = pull_r[pidx];
            default: rdata = '0;
          endcase
        end
        REQ_TICK: begin
          events_nxt = (events_r | (pads & ~levels_r & rise_en_r)
                                 | (~pads & levels_r & fall_en_r)) & PIN_MASK;
          levels_nxt = pads;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    drive_en = '0;
    for (int p = 0; p < 64; p++) begin
      if (p < NUM_PINS) begin
        drive_en[p] = (fsel_nxt[(p / 10) % FSEL_WORDS][(p % 10) * 3 +: 3] == FN_OUTPUT);
      end
    end
  end

  always_comb begin
    out_nxt                  = out_r;
    out_valid_nxt            = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt            = 1'b1;
      out_nxt.rdata            = rdata;
      out_nxt.pin_drive        = latch_nxt & PIN_MASK;
      out_nxt.pin_drive_enable = drive_en;
      out_nxt.irq              = |events_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsel_r      <= '0;
      pull_r      <= '0;
      latch_r     <= '0;
      levels_r    <= '0;
      events_r    <= '0;
      rise_en_r   <= '0;
      fall_en_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fsel_r      <= fsel_nxt;
      pull_r      <= pull_nxt;
      latch_r     <= latch_nxt;
      levels_r    <= levels_nxt;
      events_r    <= events_nxt;
      rise_en_r   <= rise_en_nxt;
      fall_en_r   <= fall_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_irq_tracks_events: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_r.irq == (|events_r)))
    else $error("irq does not match event status");

  a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.req_type != REQ_READ) |=> (out_r.rdata == '0))
    else $error("nonzero rdata on write or tick");

  a_no_phantom_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.pin_drive & ~PIN_MASK) == '0) &&
                    ((events_r & ~PIN_MASK) == '0))
    else $error("state on nonexistent pin");

  a_latch_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && in_data.req_type == REQ_WRITE) |=> $stable(latch_r))
    else $error("output latch changed without a write");
`endif

endmodule
